// ===== hdl/pcv_pkg.sv =====
package pcv_pkg;

    localparam int unsigned LEN_W   = 6;
    localparam int unsigned COUNT_W = 8;

    localparam logic [LEN_W-1:0]   CALL_MAX_LEN   = 6'd9;
    localparam logic [LEN_W-1:0]   CALL_STAR_LEN  = CALL_MAX_LEN + 6'd1;
    localparam logic [LEN_W-1:0]   IPV6_TRACE_LEN = 6'd32;
    localparam logic [LEN_W-1:0]   Q_LEN          = 6'd3;
    localparam logic [LEN_W-1:0]   LEN_SAT        = 6'd63;
    localparam logic [COUNT_W-1:0] COUNT_SAT      = 8'd255;

    localparam logic [7:0] CHAR_Q     = 8'h71;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5a;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7a;

    typedef struct packed {
        logic [LEN_W-1:0]   token_length;
        logic               first_is_q;
        logic               star_seen;
        logic               bad_char_seen;
        logic               after_q_flag;
        logic               path_bad;
        logic [COUNT_W-1:0] tokens_seen;
    } scan_state_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_byte;
        logic       empty_path;
    } in_beat_t;

    typedef struct packed {
        logic               fire;
        logic               path_valid;
        logic [COUNT_W-1:0] token_count;
    } scan_result_t;

endpackage

// ===== hdl/pcv_scan.sv =====
module pcv_scan (
    input  pcv_pkg::in_beat_t     beat,
    input  pcv_pkg::scan_state_t  state,
    output pcv_pkg::scan_state_t  state_next,
    output pcv_pkg::scan_result_t result
);

    pcv_pkg::scan_state_t taken;
    pcv_pkg::scan_state_t pre;
    pcv_pkg::scan_state_t closed;
    pcv_pkg::scan_state_t cleared;
    logic                 is_comma;
    logic                 plain_ok;
    logic                 tok_ok;
    logic                 do_close;

    always_comb begin
        cleared = '0;
        is_comma = (beat.path_byte == pcv_pkg::CHAR_COMMA);
        plain_ok = ((beat.path_byte >= pcv_pkg::CHAR_0) && (beat.path_byte <= pcv_pkg::CHAR_9))
                || ((beat.path_byte >= pcv_pkg::CHAR_UA) && (beat.path_byte <= pcv_pkg::CHAR_UZ))
                || ((beat.path_byte >= pcv_pkg::CHAR_LA) && (beat.path_byte <= pcv_pkg::CHAR_LZ))
                || (beat.path_byte == pcv_pkg::CHAR_DASH);

        // append the byte to the current token
        taken = state;
        if (state.token_length == '0) begin
            taken.first_is_q = (beat.path_byte == pcv_pkg::CHAR_Q);
        end
        if (state.star_seen || (!plain_ok && beat.path_byte != pcv_pkg::CHAR_STAR)) begin
            taken.bad_char_seen = 1'b1;
        end
        taken.star_seen = (beat.path_byte == pcv_pkg::CHAR_STAR);
        if (state.token_length < pcv_pkg::LEN_SAT) begin
            taken.token_length = state.token_length + 6'd1;
        end

        pre      = is_comma ? state : taken;
        do_close = is_comma || beat.last_byte;

        // close the token
        tok_ok = (pre.token_length != '0) && !pre.bad_char_seen;
        if (tok_ok) begin
            priority if (pre.star_seen && pre.token_length <= pcv_pkg::CALL_STAR_LEN) begin
                tok_ok = 1'b1;
            end else if (pre.token_length > pcv_pkg::CALL_MAX_LEN) begin
                tok_ok = pre.after_q_flag && (pre.token_length == pcv_pkg::IPV6_TRACE_LEN);
            end else begin
                tok_ok = 1'b1;
            end
        end
        closed = cleared;
        closed.after_q_flag = pre.after_q_flag;
        closed.path_bad     = pre.path_bad;
        closed.tokens_seen  = pre.tokens_seen;
        if (pre.tokens_seen < pcv_pkg::COUNT_SAT) begin
            closed.tokens_seen = pre.tokens_seen + 8'd1;
        end
        if (pre.first_is_q && pre.token_length == pcv_pkg::Q_LEN) begin
            closed.after_q_flag = 1'b1;
        end else if (!tok_ok) begin
            closed.path_bad = 1'b1;
        end

        result.fire        = beat.empty_path || beat.last_byte;
        result.path_valid  = beat.empty_path ? 1'b1 : !closed.path_bad;
        result.token_count = beat.empty_path ? '0 : closed.tokens_seen;

        priority if (result.fire) begin
            state_next = cleared;
        end else if (do_close) begin
            state_next = closed;
        end else begin
            state_next = taken;
        end
    end

endmodule

// ===== hdl/path_callsign_validator_unit.sv =====
// Digipeater path checker: takes one path byte per beat, splits the bytes at commas into
// tokens, checks each non-Q token as a callsign and, on the last byte or an empty-path beat,
// returns one result beat with the path valid flag and the saturating token count. A byte
// is taken every cycle unless a final byte waits for the result register. The result beat
// is offered from the result register, fed from the input register by the combinational
// scan update. Bytes that end no path keep moving while a result waits to be taken, and a
// final byte waits in the input register until the result register is free.
module path_callsign_validator_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_path_byte,
    input  logic       s_last_byte,
    input  logic       s_empty_path,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_path_valid,
    output logic [7:0] m_token_count
);

    logic                  in_valid_reg;
    pcv_pkg::in_beat_t     in_beat_reg;
    pcv_pkg::scan_state_t  state_reg;
    pcv_pkg::scan_state_t  state_next;
    pcv_pkg::scan_result_t result;
    logic                  out_valid_reg;
    logic                  out_path_valid_reg;
    logic [7:0]            out_count_reg;
    logic                  advance;

    pcv_scan u_scan (
        .beat       (in_beat_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // a byte that gives no result never waits on the output side
    assign advance = in_valid_reg && (!result.fire || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && result.fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg.path_byte  <= s_path_byte;
            in_beat_reg.last_byte  <= s_last_byte;
            in_beat_reg.empty_path <= s_empty_path;
        end
        if (advance && result.fire) begin
            out_path_valid_reg <= result.path_valid;
            out_count_reg      <= result.token_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_path_valid  = out_path_valid_reg;
    assign m_token_count = out_count_reg;

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_beat_reg.empty_path |=> m_valid && m_path_valid && m_token_count == 8'd0)
        else $error("empty path beat did not give a clean result");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.fire |=> state_reg == '0)
        else $error("scan state not cleared after result");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !(advance && result.fire))
        else $error("result overwritten while stalled");

endmodule

// ===== sim/tb_path_callsign_validator_unit.sv =====
module tb_path_callsign_validator_unit;

    typedef struct {
        logic [7:0] pb;
        logic       last;
        logic       empty;
        logic       drain;
    } path_beat_t;

    typedef struct {
        logic       path_valid;
        logic [7:0] token_count;
    } path_result_t;

    typedef enum logic [1:0] {
        IDLE_RECV_HEAVY,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_phase_t;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned SAT_PATH_LEN = 260;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_path_byte = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       s_empty_path = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_path_valid;
    logic [7:0] m_token_count;

    path_beat_t   pending_beats[$];
    path_result_t path_results_q[$];
    logic [7:0]   path_buf[$];

    logic [pcv_pkg::LEN_W-1:0]   tok_len;
    logic                        tok_first_q;
    logic                        tok_star;
    logic                        tok_bad;
    logic                        seen_q;
    logic                        path_bad_r;
    logic [pcv_pkg::COUNT_W-1:0] tok_count;

    logic        in_taken = 1'b0;
    logic        drain_wait = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned phase_step = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    idle_phase_t idle_phase = IDLE_RECV_HEAVY;

    path_callsign_validator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_path_byte   (s_path_byte),
        .s_last_byte   (s_last_byte),
        .s_empty_path  (s_empty_path),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_path_valid  (m_path_valid),
        .m_token_count (m_token_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always_comb begin
        case (idle_phase)
            IDLE_RECV_HEAVY: begin
                send_idle_pct = 25;
                recv_idle_pct = 54;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 54;
                recv_idle_pct = 25;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    end

    // path scanner prediction
    function automatic bit is_call_char(input logic [7:0] c);
        return (c >= pcv_pkg::CHAR_0 && c <= pcv_pkg::CHAR_9) ||
               (c >= pcv_pkg::CHAR_UA && c <= pcv_pkg::CHAR_UZ) ||
               (c >= pcv_pkg::CHAR_LA && c <= pcv_pkg::CHAR_LZ) ||
               (c == pcv_pkg::CHAR_DASH);
    endfunction

    task automatic clear_token();
        tok_len     = '0;
        tok_first_q = 1'b0;
        tok_star    = 1'b0;
        tok_bad     = 1'b0;
    endtask

    task automatic clear_path();
        clear_token();
        seen_q     = 1'b0;
        path_bad_r = 1'b0;
        tok_count  = '0;
    endtask

    task automatic close_token();
        bit ok;
        if (tok_count != pcv_pkg::COUNT_SAT) tok_count = tok_count + 1'b1;
        if (tok_first_q && tok_len == pcv_pkg::Q_LEN) begin
            seen_q = 1'b1;
        end else begin
            ok = (tok_len != 0) && !tok_bad;
            if (ok) begin
                if (tok_star && tok_len <= pcv_pkg::CALL_STAR_LEN) begin
                    ok = 1'b1;
                end else if (tok_len > pcv_pkg::CALL_MAX_LEN) begin
                    ok = seen_q && (tok_len == pcv_pkg::IPV6_TRACE_LEN);
                end
            end
            if (!ok) path_bad_r = 1'b1;
        end
        clear_token();
    endtask

    task automatic scan_beat(input logic [7:0] pb, input logic last, input logic empty);
        path_result_t r;
        if (empty) begin
            clear_path();
            r.path_valid  = 1'b1;
            r.token_count = '0;
            path_results_q.push_back(r);
        end else begin
            if (pb == pcv_pkg::CHAR_COMMA) begin
                close_token();
            end else begin
                if (tok_len == 0) tok_first_q = (pb == pcv_pkg::CHAR_Q);
                if (tok_star) tok_bad = 1'b1;
                if (!is_call_char(pb) && pb != pcv_pkg::CHAR_STAR) tok_bad = 1'b1;
                tok_star = (pb == pcv_pkg::CHAR_STAR);
                if (tok_len != pcv_pkg::LEN_SAT) tok_len = tok_len + 1'b1;
                if (last) close_token();
            end
            if (last) begin
                r.path_valid  = !path_bad_r;
                r.token_count = tok_count;
                path_results_q.push_back(r);
                clear_path();
            end
        end
    endtask

    // stimulus building
    task automatic put_beat(input logic [7:0] pb, input logic last, input logic empty);
        path_beat_t nb;
        nb.pb    = pb;
        nb.last  = last;
        nb.empty = empty;
        nb.drain = 1'b0;
        pending_beats.push_back(nb);
    endtask

    task automatic put_drain();
        path_beat_t nb;
        nb.pb    = 8'h00;
        nb.last  = 1'b0;
        nb.empty = 1'b0;
        nb.drain = 1'b1;
        pending_beats.push_back(nb);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_beat(s[i], i == s.len() - 1, 1'b0);
    endtask

    function automatic logic [7:0] call_char();
        string alphabet;
        alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    function automatic logic [7:0] hex_char();
        string alphabet;
        alphabet = "0123456789ABCDEFabcdef";
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    function automatic logic [7:0] any_but_comma();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == pcv_pkg::CHAR_COMMA) v = v ^ 8'h01;
        return v;
    endfunction

    task automatic add_token();
        int roll;
        int n;
        int bad_at;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            n = $urandom_range(1, pcv_pkg::CALL_MAX_LEN);
            repeat (n) path_buf.push_back(call_char());
        end else if (roll < 50) begin
            n = $urandom_range(0, pcv_pkg::CALL_MAX_LEN);
            repeat (n) path_buf.push_back(call_char());
            path_buf.push_back(pcv_pkg::CHAR_STAR);
        end else if (roll < 62) begin
            path_buf.push_back(pcv_pkg::CHAR_Q);
            repeat (2) path_buf.push_back(any_but_comma());
        end else if (roll < 70) begin
            repeat (pcv_pkg::IPV6_TRACE_LEN) path_buf.push_back(hex_char());
            if ($urandom_range(0, 3) == 0) path_buf.push_back(pcv_pkg::CHAR_STAR);
        end else if (roll < 78) begin
            case ($urandom_range(0, 2))
                0: n = $urandom_range(pcv_pkg::CALL_MAX_LEN - 1, pcv_pkg::CALL_MAX_LEN + 3);
                1: n = $urandom_range(pcv_pkg::IPV6_TRACE_LEN - 2, pcv_pkg::IPV6_TRACE_LEN + 2);
                default: n = $urandom_range(pcv_pkg::LEN_SAT - 3, pcv_pkg::LEN_SAT + 7);
            endcase
            repeat (n) path_buf.push_back(call_char());
        end else if (roll < 84) begin
            path_buf.push_back(pcv_pkg::CHAR_Q);
            n = $urandom_range(0, 3);
            repeat (n) path_buf.push_back(call_char());
        end else if (roll < 90) begin
            // empty token
        end else if (roll < 96) begin
            n = $urandom_range(1, pcv_pkg::CALL_MAX_LEN);
            bad_at = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++) begin
                path_buf.push_back(i == bad_at ? any_but_comma() : call_char());
            end
        end else begin
            path_buf.push_back(call_char());
            path_buf.push_back(pcv_pkg::CHAR_STAR);
            path_buf.push_back(call_char());
        end
    endtask

    task automatic add_path();
        int ntok;
        int n;
        path_buf.delete();
        if ($urandom_range(0, 99) < 4) begin
            n = $urandom_range(1, 20);
            repeat (n) path_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                if (t != 0) path_buf.push_back(pcv_pkg::CHAR_COMMA);
                add_token();
            end
            if ($urandom_range(0, 9) == 0) path_buf.push_back(pcv_pkg::CHAR_COMMA);
        end
        if (path_buf.size() == 0) path_buf.push_back(pcv_pkg::CHAR_COMMA);
        if ($urandom_range(0, 29) == 0) begin
            // abandoned partial path
            foreach (path_buf[i]) put_beat(path_buf[i], 1'b0, 1'b0);
            put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            foreach (path_buf[i]) put_beat(path_buf[i], i == path_buf.size() - 1, 1'b0);
        end
        if ($urandom_range(0, 19) == 0) begin
            put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // driver
    always @(negedge aclk) begin : drive_proc
        path_beat_t nb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (drain_wait) begin
            if (path_results_q.size() == 0) drain_wait <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_beats.size() != 0 && pending_beats[0].drain) begin
                nb = pending_beats.pop_front();
                drain_wait <= 1'b1;
                s_valid <= 1'b0;
            end else if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nb = pending_beats.pop_front();
                s_path_byte  <= nb.pb;
                s_last_byte  <= nb.last;
                s_empty_path <= nb.empty;
                s_valid      <= 1'b1;
                beats_sent   <= beats_sent + 1;
                if (beats_sent + 1 >= 2 * phase_step) begin
                    idle_phase <= IDLE_NONE;
                end else if (beats_sent + 1 >= phase_step) begin
                    idle_phase <= IDLE_SEND_HEAVY;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin : recv_proc
        int unsigned hold_left;
        bit          hold_one_done;
        bit          hold_two_done;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_one_done && results_seen >= 10) begin
            hold_one_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (!hold_two_done && idle_phase == IDLE_NONE) begin
            hold_two_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin : mon_proc
        path_result_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) scan_beat(s_path_byte, s_last_byte, s_empty_path);
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (path_results_q.size() == 0) begin
                    $error("result beat with nothing expected: path_valid %0d token_count %0d",
                           m_path_valid, m_token_count);
                    error_count = error_count + 1;
                end else begin
                    want = path_results_q.pop_front();
                    if (m_path_valid !== want.path_valid) begin
                        $error("path_valid: expected %0d, actual %0d",
                               want.path_valid, m_path_valid);
                        error_count = error_count + 1;
                    end
                    if (m_token_count !== want.token_count) begin
                        $error("token_count: expected %0d, actual %0d",
                               want.token_count, m_token_count);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    initial begin
        #(4 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main_proc
        bit mid_drain_done;
        clear_path();
        mid_drain_done = 1'b0;

        put_beat(8'hff, 1'b0, 1'b1);
        put_text(",");
        put_text("A,");
        put_text("qAR");
        put_beat(8'h80, 1'b1, 1'b0);
        put_beat(8'h00, 1'b1, 1'b0);
        put_text("9*");
        put_text("*a");
        put_beat(pcv_pkg::CHAR_UA, 1'b0, 1'b0);
        put_beat(pcv_pkg::CHAR_UA + 8'd1, 1'b0, 1'b0);
        put_beat(pcv_pkg::CHAR_COMMA, 1'b1, 1'b1);
        put_text("-,,Z");
        put_drain();

        // token count saturation
        repeat (SAT_PATH_LEN - 1) put_beat(pcv_pkg::CHAR_COMMA, 1'b0, 1'b0);
        put_beat(pcv_pkg::CHAR_COMMA, 1'b1, 1'b0);

        while (pending_beats.size() < 1530) begin
            add_path();
            if (!mid_drain_done && pending_beats.size() > 900) begin
                put_drain();
                mid_drain_done = 1'b1;
            end
        end
        phase_step = pending_beats.size() / 3;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid || drain_wait) @(posedge aclk);
        while (path_results_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (path_results_q.size() != 0) begin
            $error("%0d expected result beats never arrived", path_results_q.size());
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pcv_pkg.sv
hdl/pcv_scan.sv
hdl/path_callsign_validator_unit.sv
sim/tb_path_callsign_validator_unit.sv
